### rtl/mpct_pkg.sv
`default_nettype none
package mpct_pkg;

	// Payload types
	typedef logic [7:0] byte_t;
	typedef logic [8:0] coord_t;

	// Header bit positions
	localparam int unsigned HDR_LEFT_BIT    = 0;
	localparam int unsigned HDR_RIGHT_BIT   = 1;
	localparam int unsigned HDR_ALWAYS1_BIT = 3;
	localparam int unsigned HDR_XSIGN_BIT   = 4;
	localparam int unsigned HDR_YSIGN_BIT   = 5;

	// Register indexes (word address bit 2)
	localparam logic REG_MAX_X = 1'b0;
	localparam logic REG_MAX_Y = 1'b1;

	// Reset values
	localparam coord_t MAX_X_RESET = 9'd319;
	localparam coord_t MAX_Y_RESET = 9'd199;
	localparam coord_t POS_X_RESET = 9'd160;
	localparam coord_t POS_Y_RESET = 9'd100;

	// Packet framing phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_X      = 2'd1,
		PH_Y      = 2'd2
	} phase_t;

endpackage
`default_nettype wire

### rtl/mpct_byte_if.sv
`default_nettype none
interface mpct_byte_if import mpct_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/mpct_cursor_if.sv
`default_nettype none
interface mpct_cursor_if import mpct_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t x_pos;
	coord_t y_pos;
	logic   left_down;
	logic   right_down;

	modport source (output valid, output x_pos, output y_pos,
		output left_down, output right_down, input ready);
	modport sink (input valid, input x_pos, input y_pos,
		input left_down, input right_down, output ready);
endinterface
`default_nettype wire

### rtl/mouse_packet_cursor_tracker.sv
// PS/2 mouse packet decoder with cursor tracking.
// The mouse channel takes one received byte per word; bytes are framed into
// packets of header, X movement and Y movement. A header word without its
// always-one bit is dropped to regain framing. After each Y byte one word
// goes out on the cursor channel with the clamped position and the left and
// right button levels from that packet's header.
// Each byte passes an input register and one stage of update logic into the
// output register; a result word is written there once its Y byte in the input
// register can advance. One byte is taken every cycle unless a Y byte waits for
// the output register to be freed.
// The APB port holds max_x at address 0 and max_y at address 4; write them
// only while no byte is in flight.
// Reset returns framing to the header phase, the cursor to (160, 100), and
// the limits to 319 and 199. While the cursor receiver stalls, the output
// word holds; header and X bytes still advance, and the mouse channel stalls
// once the next packet's Y byte waits in the input register.
`default_nettype none
module mouse_packet_cursor_tracker import mpct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	mpct_byte_if.sink        mouse,
	mpct_cursor_if.source    cursor
);

	coord_t        max_x_q;
	coord_t        max_y_q;
	logic          valid_s1;
	byte_t         byte_s1;
	phase_t        phase_q;
	phase_t        phase_d;
	byte_t         hdr_q;
	byte_t         xdel_q;
	coord_t        pos_x_q;
	coord_t        pos_y_q;
	logic          out_valid_q;
	coord_t        out_x_q;
	coord_t        out_y_q;
	logic          out_left_q;
	logic          out_right_q;
	logic          out_free;
	logic          done;
	logic          adv;
	logic          load_hdr;
	logic          load_x;
	logic signed [10:0] dx;
	logic signed [10:0] dy;
	logic signed [10:0] nx;
	logic signed [10:0] ny;
	coord_t        cx;
	coord_t        cy;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MAX_X: max_x_q <= pwdata[8:0];
				REG_MAX_Y: max_y_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_X: prdata = {23'd0, max_x_q};
			REG_MAX_Y: prdata = {23'd0, max_y_q};
			default:   prdata = 32'd0;
		endcase
	end

	// Handshake: advance the input stage unless a result has nowhere to go
	assign out_free   = !out_valid_q || cursor.ready;
	assign done       = valid_s1 && (phase_q == PH_Y);
	assign adv        = valid_s1 && (!done || out_free);
	assign mouse.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mouse.ready) begin
			valid_s1 <= mouse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mouse.valid && mouse.ready) begin
			byte_s1 <= mouse.rx_byte;
		end
	end

	// Next framing phase
	always_comb begin
		case (phase_q)
			PH_HEADER: phase_d = byte_s1[HDR_ALWAYS1_BIT] ? PH_X : PH_HEADER;
			PH_X:      phase_d = PH_Y;
			PH_Y:      phase_d = PH_HEADER;
			default:   phase_d = byte_s1[HDR_ALWAYS1_BIT] ? PH_X : PH_HEADER;
		endcase
	end

	// Phase outputs: which byte register to load
	always_comb begin
		load_hdr = 1'b0;
		load_x   = 1'b0;
		case (phase_q)
			PH_X:    load_x = adv;
			PH_Y:    ;
			default: load_hdr = adv && byte_s1[HDR_ALWAYS1_BIT];
		endcase
	end

	// Move and clamp the cursor
	always_comb begin
		dx = {{3{hdr_q[HDR_XSIGN_BIT]}}, xdel_q};
		dy = {{3{hdr_q[HDR_YSIGN_BIT]}}, byte_s1};
		nx = $signed({2'b00, pos_x_q}) + dx;
		ny = $signed({2'b00, pos_y_q}) - dy;
		if (nx[10]) begin
			cx = '0;
		end else if (nx[9:0] > {1'b0, max_x_q}) begin
			cx = max_x_q;
		end else begin
			cx = nx[8:0];
		end
		if (ny[10]) begin
			cy = '0;
		end else if (ny[9:0] > {1'b0, max_y_q}) begin
			cy = max_y_q;
		end else begin
			cy = ny[8:0];
		end
	end

	// Framing state and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			xdel_q  <= '0;
			pos_x_q <= POS_X_RESET;
			pos_y_q <= POS_Y_RESET;
		end else if (adv) begin
			phase_q <= phase_d;
			if (load_hdr) begin
				hdr_q <= byte_s1;
			end
			if (load_x) begin
				xdel_q <= byte_s1;
			end
			if (done) begin
				pos_x_q <= cx;
				pos_y_q <= cy;
			end
		end
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && done) begin
			out_valid_q <= 1'b1;
		end else if (cursor.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done) begin
			out_x_q     <= cx;
			out_y_q     <= cy;
			out_left_q  <= hdr_q[HDR_LEFT_BIT];
			out_right_q <= hdr_q[HDR_RIGHT_BIT];
		end
	end

	assign cursor.valid      = out_valid_q;
	assign cursor.x_pos      = out_x_q;
	assign cursor.y_pos      = out_y_q;
	assign cursor.left_down  = out_left_q;
	assign cursor.right_down = out_right_q;

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mpct_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   left;
		logic   right;
	} cursor_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mpct_byte_if   mouse_ch ();
	mpct_cursor_if cursor_ch ();

	mouse_packet_cursor_tracker uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mouse   (mouse_ch),
		.cursor  (cursor_ch)
	);

	// Bytes waiting to be sent and cursor words waiting to be seen
	byte_t        pending_bytes[$];
	cursor_word_t cursor_expect[$];

	// Tracker state mirrored from the block
	phase_t trk_phase;
	byte_t  trk_hdr;
	byte_t  trk_xbyte;
	coord_t trk_px;
	coord_t trk_py;
	coord_t lim_x;
	coord_t lim_y;

	int   error_count;
	int   bytes_sent;
	int   words_checked;
	int   limit_settings;
	int   cycle_count;
	int   hold_left;
	logic hold_go;
	logic send_calm;
	logic recv_calm;
	cursor_word_t got_word;
	cursor_word_t want_word;

	// Free-running clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic coord_t clamp_coord(input int v, input coord_t hi);
		if (v < 0)
			return '0;
		if (v > int'(hi))
			return hi;
		return coord_t'(v);
	endfunction

	// Advance the framing and cursor for one accepted byte
	function automatic void track_byte(input byte_t b);
		int nx;
		int ny;
		cursor_word_t w;
		case (trk_phase)
			PH_X: begin
				trk_xbyte = b;
				trk_phase = PH_Y;
			end
			PH_Y: begin
				nx = int'(trk_px) + int'(trk_xbyte) - (trk_hdr[HDR_XSIGN_BIT] ? 256 : 0);
				ny = int'(trk_py) - (int'(b) - (trk_hdr[HDR_YSIGN_BIT] ? 256 : 0));
				trk_px = clamp_coord(nx, lim_x);
				trk_py = clamp_coord(ny, lim_y);
				w.x = trk_px;
				w.y = trk_py;
				w.left = trk_hdr[HDR_LEFT_BIT];
				w.right = trk_hdr[HDR_RIGHT_BIT];
				cursor_expect.push_back(w);
				trk_phase = PH_HEADER;
			end
			default: begin
				// drop a header without its always-one bit
				if (b[HDR_ALWAYS1_BIT]) begin
					trk_hdr = b;
					trk_phase = PH_X;
				end else begin
					trk_phase = PH_HEADER;
				end
			end
		endcase
	endfunction

	function automatic void push_packet(input byte_t hdr, input byte_t dx, input byte_t dy);
		pending_bytes.push_back(hdr);
		pending_bytes.push_back(dx);
		pending_bytes.push_back(dy);
	endfunction

	// Mostly well-formed packets, some dropped headers and cut-short packets
	function automatic void queue_random(input int n_bytes);
		int pushed;
		int r;
		byte_t hdr;
		pushed = 0;
		while (pushed < n_bytes) begin
			r = $urandom_range(99);
			hdr = byte_t'($urandom) | (byte_t'(1) << HDR_ALWAYS1_BIT);
			if (r < 80) begin
				push_packet(hdr, byte_t'($urandom), byte_t'($urandom));
				pushed += 3;
			end else if (r < 90) begin
				pending_bytes.push_back(byte_t'($urandom) & ~(byte_t'(1) << HDR_ALWAYS1_BIT));
			end else begin
				pending_bytes.push_back(hdr);
				pending_bytes.push_back(byte_t'($urandom));
				pushed += 2;
			end
		end
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_limits();
		logic [31:0] rd;
		apb_read({REG_MAX_X, 2'b00}, rd);
		if (rd !== 32'(lim_x))
			note_error($sformatf("max_x read: exp %0d got %0d", lim_x, rd));
		apb_read({REG_MAX_Y, 2'b00}, rd);
		if (rd !== 32'(lim_y))
			note_error($sformatf("max_y read: exp %0d got %0d", lim_y, rd));
	endtask

	task automatic set_limits(input coord_t mx, input coord_t my);
		apb_write({REG_MAX_X, 2'b00}, 32'(mx));
		apb_write({REG_MAX_Y, 2'b00}, 32'(my));
		lim_x = mx;
		lim_y = my;
		limit_settings++;
		check_limits();
	endtask

	// Hold the sender until every word is out and the pipe is quiet
	task automatic drain();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || mouse_ch.valid);
		while (cursor_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mouse byte driver; mirror the tracker on each accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			mouse_ch.valid <= 1'b0;
			mouse_ch.rx_byte <= '0;
		end else begin
			if (mouse_ch.valid && mouse_ch.ready) begin
				track_byte(mouse_ch.rx_byte);
				bytes_sent++;
			end
			if (!mouse_ch.valid || mouse_ch.ready) begin
				if (pending_bytes.size() != 0 && (send_calm || $urandom_range(99) >= 27)) begin
					mouse_ch.valid <= 1'b1;
					mouse_ch.rx_byte <= pending_bytes.pop_front();
				end else begin
					mouse_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Count down a long receiver hold-off
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Cursor receiver ready
	always @(posedge clk) begin
		if (!arst_n)
			cursor_ch.ready <= 1'b0;
		else
			cursor_ch.ready <= (hold_left == 0) && (recv_calm || $urandom_range(99) >= 27);
	end

	// Compare each accepted cursor word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && cursor_ch.valid && cursor_ch.ready) begin
			got_word.x = cursor_ch.x_pos;
			got_word.y = cursor_ch.y_pos;
			got_word.left = cursor_ch.left_down;
			got_word.right = cursor_ch.right_down;
			if (cursor_expect.size() == 0) begin
				note_error($sformatf("unexpected cursor word x=%0d y=%0d l=%0b r=%0b",
					got_word.x, got_word.y, got_word.left, got_word.right));
			end else begin
				want_word = cursor_expect.pop_front();
				if (got_word.x !== want_word.x || got_word.y !== want_word.y ||
						got_word.left !== want_word.left || got_word.right !== want_word.right)
					note_error($sformatf(
						"cursor word %0d: exp x=%0d y=%0d l=%0b r=%0b got x=%0d y=%0d l=%0b r=%0b",
						words_checked, want_word.x, want_word.y, want_word.left, want_word.right,
						got_word.x, got_word.y, got_word.left, got_word.right));
			end
			words_checked++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mouse_ch.valid = 1'b0;
		mouse_ch.rx_byte = '0;
		cursor_ch.ready = 1'b0;
		hold_go = 1'b0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		error_count = 0;
		bytes_sent = 0;
		words_checked = 0;
		limit_settings = 0;
		cycle_count = 0;
		trk_phase = PH_HEADER;
		trk_hdr = '0;
		trk_xbyte = '0;
		trk_px = POS_X_RESET;
		trk_py = POS_Y_RESET;
		lim_x = MAX_X_RESET;
		lim_y = MAX_Y_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits, dropped headers, sign and clamp corners
		check_limits();
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hF7);
		push_packet(8'h08, 8'h00, 8'h00);
		push_packet(8'h0B, 8'h7F, 8'h80);
		push_packet(8'h38, 8'h00, 8'h00);
		push_packet(8'hFF, 8'hFF, 8'hFF);
		push_packet(8'h18, 8'h01, 8'h7F);
		push_packet(8'hC9, 8'h80, 8'hFF);
		drain();

		// Long stretch with no idling on either side
		send_calm <= 1'b1;
		recv_calm <= 1'b1;
		queue_random(200);
		drain();
		send_calm <= 1'b0;
		recv_calm <= 1'b0;

		// Full range; stall the receiver while bytes keep coming
		set_limits(9'd511, 9'd511);
		send_calm <= 1'b1;
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		queue_random(200);
		drain();
		send_calm <= 1'b0;

		// Smallest limits, then zero
		set_limits(9'd1, 9'd1);
		queue_random(100);
		drain();
		set_limits(9'd0, 9'd0);
		queue_random(60);
		drain();

		// Push the cursor far out, then lower the limits below it
		set_limits(9'd511, 9'd511);
		repeat (6) push_packet(8'h28, 8'h7F, 8'h81);
		drain();
		set_limits(9'd40, 9'd30);
		queue_random(150);
		drain();

		// Random limits
		repeat (3) begin
			set_limits(coord_t'($urandom_range(511, 1)), coord_t'($urandom_range(511, 1)));
			queue_random(100);
			drain();
		end

		$display("Sent %0d mouse bytes and checked %0d cursor words over %0d limit settings,",
			bytes_sent, words_checked, limit_settings);
		$display("covering dropped headers, cut packets, zero and full-range clamps and a long stall.");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
